// ----- rtl/core/cmfl_pkg.sv -----
`default_nettype none
package cmfl_pkg;

  localparam int NUM_INPUTS  = 16;
  localparam int MAX_VCI     = 16;
  localparam int QUEUE_DEPTH = 64;

  localparam int LINE_AW  = $clog2(NUM_INPUTS);
  localparam int VCI_AW   = $clog2(MAX_VCI);
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths
  localparam int CMD_W   = 3;
  localparam int LINE_W  = 4;
  localparam int VCI_W   = 16;
  localparam int TAG_W   = 32;
  localparam int IDX_W   = 4;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 32;
  localparam int LIMIT_W = 7;
  localparam int QLEN_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  typedef enum logic [CMD_W-1:0] {
    CMD_ARRIVE    = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_READ_LINE = 3'd3,
    CMD_READ_VCI  = 3'd4
  } command_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED  = 3'd0,
    KIND_DROPPED = 3'd1,
    KIND_SENT    = 3'd2,
    KIND_IDLE    = 3'd3,
    KIND_READ    = 3'd4,
    KIND_CLEARED = 3'd5
  } kind_t;

endpackage
`default_nettype wire

// ----- rtl/core/cmfl_if.sv -----
`default_nettype none
interface cmfl_in_if;
  import cmfl_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [LINE_W-1:0]  input_line;
  logic [VCI_W-1:0]   cell_vci;
  logic               has_vci;
  logic [TAG_W-1:0]   cell_tag;
  logic [IDX_W-1:0]   counter_index;

  modport source (output valid, command, input_line, cell_vci, has_vci, cell_tag,
                  counter_index, input ready);
  modport sink (input valid, command, input_line, cell_vci, has_vci, cell_tag,
                counter_index, output ready);
endinterface

interface cmfl_out_if;
  import cmfl_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [TAG_W-1:0]   out_tag;
  logic [VCI_W-1:0]   out_vci;
  logic [CNT_W-1:0]   counter_value;
  logic [QLEN_W-1:0]  queue_length;
  logic [CNT_W-1:0]   total_losses;
  logic               counter_wrapped;

  modport source (output valid, result_kind, out_tag, out_vci, counter_value,
                  queue_length, total_losses, counter_wrapped, input ready);
  modport sink (input valid, result_kind, out_tag, out_vci, counter_value,
                queue_length, total_losses, counter_wrapped, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cell_mux_fifo_loss_counter_core.sv -----
// Slotted cell multiplexer with a bounded FIFO and loss counters.
// req carries commands: cell arrival, slot tick, clear losses, read line loss,
// read VCI loss. rsp returns one result beat per known command; unknown
// commands are consumed silently.
// cfg_we/cfg_data write buffer_limit (saturates at the queue depth); write
// only while the block is idle.
// Each command is accepted in ST_IDLE, which also launches the registered
// reads of the cell queue RAM and the two loss counter RAMs; the next cycle
// (ST_EXEC) does the read-modify-write and loads the result register. A new
// command is accepted only once that update is done, since the synchronous
// RAM read sits in front of the update.
// The next command is accepted in the same cycle the result is taken, so a
// stalled receiver holds rsp steady and blocks req until it takes the beat.
// Reset empties the queue, zeroes the total, sets buffer_limit to 10 and
// clears the counter valid bits, so every loss counter reads zero at once;
// the clear command zeroes total and valid bits. No clearing pass is needed.
`default_nettype none
module cell_mux_fifo_loss_counter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cmfl_pkg::LIMIT_W-1:0]  cfg_data,
  cmfl_in_if.sink                       req,
  cmfl_out_if.source                    rsp
);
  import cmfl_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t               state;
  logic [LIMIT_W-1:0]   limit;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [FILL_W-1:0]    fill;
  logic [FILL_W-1:0]    slot_fill;
  logic [CNT_W-1:0]     loss_sum;
  logic [NUM_INPUTS-1:0] line_valid;
  logic [MAX_VCI-1:0]   vci_valid;

  // captured command
  logic [CMD_W-1:0]     c_cmd;
  logic [LINE_W-1:0]    c_line;
  logic [VCI_W-1:0]     c_vci;
  logic                 c_has_vci;
  logic [TAG_W-1:0]     c_tag;
  logic [IDX_W-1:0]     c_idx;

  // memories
  logic [VCI_W+TAG_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [CNT_W-1:0]       line_mem  [NUM_INPUTS];
  logic [CNT_W-1:0]       vci_mem   [MAX_VCI];
  logic [VCI_W+TAG_W-1:0] q_rd;
  logic [CNT_W-1:0]       line_rd;
  logic [CNT_W-1:0]       vci_rd;
  logic                   line_rd_ok;
  logic                   vci_rd_ok;

  // result register
  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [TAG_W-1:0]     out_tag;
  logic [VCI_W-1:0]     out_vci;
  logic [CNT_W-1:0]     out_cval;
  logic                 out_wrap;

  logic                 acc;
  logic                 exec;
  logic [LINE_AW-1:0]   line_raddr;
  logic [VCI_AW-1:0]    vci_raddr;
  logic [LINE_AW-1:0]   line_waddr;
  logic [VCI_AW-1:0]    vci_waddr;
  logic [FILL_W-1:0]    eff_limit;
  logic                 has_room;
  logic                 line_ok;
  logic                 vci_ok;
  logic                 idx_line_ok;
  logic                 idx_vci_ok;
  logic                 sends;
  logic [CNT_W-1:0]     line_inc;
  logic [CNT_W-1:0]     vci_inc;
  logic [CNT_W-1:0]     sum_inc;
  logic                 q_we;
  logic                 line_we;
  logic                 vci_we;

  logic [QUEUE_AW-1:0]  rd_ptr_next;
  logic [QUEUE_AW-1:0]  wr_ptr_next;
  logic [FILL_W-1:0]    fill_next;
  logic [FILL_W-1:0]    slot_fill_next;
  logic [CNT_W-1:0]     loss_sum_next;
  logic                 res_valid;
  logic [KIND_W-1:0]    res_kind;
  logic [TAG_W-1:0]     res_tag;
  logic [VCI_W-1:0]     res_vci;
  logic [CNT_W-1:0]     res_cval;
  logic                 res_wrap;

  assign acc  = req.valid && req.ready;
  assign exec = (state == ST_EXEC);
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);

  assign line_raddr = (command_t'(req.command) == CMD_READ_LINE) ?
                      LINE_AW'(req.counter_index) : LINE_AW'(req.input_line);
  assign vci_raddr  = (command_t'(req.command) == CMD_READ_VCI) ?
                      VCI_AW'(req.counter_index) : VCI_AW'(req.cell_vci);
  assign line_waddr = LINE_AW'(c_line);
  assign vci_waddr  = VCI_AW'(c_vci);

  assign eff_limit   = (int'(limit) > QUEUE_DEPTH) ? FILL_W'(QUEUE_DEPTH) : FILL_W'(limit);
  assign has_room    = fill < eff_limit;
  assign line_ok     = int'(c_line) < NUM_INPUTS;
  assign vci_ok      = c_has_vci && (int'(c_vci) < MAX_VCI);
  assign idx_line_ok = int'(c_idx) < NUM_INPUTS;
  assign idx_vci_ok  = int'(c_idx) < MAX_VCI;
  assign sends       = (slot_fill != '0) && (fill != '0);

  // invalid entries read as zero
  assign line_inc = (line_rd_ok ? line_rd : '0) + CNT_W'(1);
  assign vci_inc  = (vci_rd_ok ? vci_rd : '0) + CNT_W'(1);
  assign sum_inc  = loss_sum + CNT_W'(1);

  assign q_we    = exec && (command_t'(c_cmd) == CMD_ARRIVE) && has_room;
  assign line_we = exec && (command_t'(c_cmd) == CMD_ARRIVE) && !has_room && line_ok;
  assign vci_we  = exec && (command_t'(c_cmd) == CMD_ARRIVE) && !has_room && vci_ok;

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    fill_next      = fill;
    slot_fill_next = slot_fill;
    loss_sum_next  = loss_sum;
    res_valid      = 1'b1;
    res_kind       = KIND_QUEUED;
    res_tag        = '0;
    res_vci        = '0;
    res_cval       = '0;
    res_wrap       = 1'b0;
    case (command_t'(c_cmd))
      CMD_ARRIVE: begin
        if (has_room) begin
          wr_ptr_next = (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
          fill_next   = fill + FILL_W'(1);
        end else begin
          res_kind      = KIND_DROPPED;
          loss_sum_next = sum_inc;
          res_wrap      = (line_ok && line_inc == '0) || (vci_ok && vci_inc == '0) ||
                          (sum_inc == '0);
        end
      end
      CMD_TICK: begin
        if (sends) begin
          res_kind    = KIND_SENT;
          res_tag     = q_rd[TAG_W-1:0];
          res_vci     = q_rd[VCI_W+TAG_W-1:TAG_W];
          rd_ptr_next = (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
          fill_next   = fill - FILL_W'(1);
        end else begin
          res_kind = KIND_IDLE;
        end
        slot_fill_next = fill_next;
      end
      CMD_CLEAR: begin
        res_kind      = KIND_CLEARED;
        loss_sum_next = '0;
      end
      CMD_READ_LINE: begin
        res_kind = KIND_READ;
        res_cval = (idx_line_ok && line_rd_ok) ? line_rd : '0;
      end
      CMD_READ_VCI: begin
        res_kind = KIND_READ;
        res_cval = (idx_vci_ok && vci_rd_ok) ? vci_rd : '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      limit      <= LIMIT_RESET;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fill       <= '0;
      slot_fill  <= '0;
      loss_sum   <= '0;
      line_valid <= '0;
      vci_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (exec && res_valid) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state     <= ST_IDLE;
          rd_ptr    <= rd_ptr_next;
          wr_ptr    <= wr_ptr_next;
          fill      <= fill_next;
          slot_fill <= slot_fill_next;
          loss_sum  <= loss_sum_next;
          if (command_t'(c_cmd) == CMD_CLEAR) begin
            line_valid <= '0;
            vci_valid  <= '0;
          end
          if (line_we) begin
            line_valid[line_waddr] <= 1'b1;
          end
          if (vci_we) begin
            vci_valid[vci_waddr] <= 1'b1;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      c_cmd     <= req.command;
      c_line    <= req.input_line;
      c_vci     <= req.cell_vci;
      c_has_vci <= req.has_vci;
      c_tag     <= req.cell_tag;
      c_idx     <= req.counter_index;
    end
    if (exec && res_valid) begin
      out_kind <= res_kind;
      out_tag  <= res_tag;
      out_vci  <= res_vci;
      out_cval <= res_cval;
      out_wrap <= res_wrap;
    end
    line_rd_ok <= line_valid[line_raddr];
    vci_rd_ok  <= vci_valid[vci_raddr];
  end

  // cell queue RAM
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[wr_ptr] <= {(c_has_vci ? c_vci : VCI_W'(0)), c_tag};
    end
    q_rd <= queue_mem[rd_ptr];
  end

  // per-line loss counter RAM
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_inc;
    end
    line_rd <= line_mem[line_raddr];
  end

  // per-VCI loss counter RAM
  always_ff @(posedge clk) begin
    if (vci_we) begin
      vci_mem[vci_waddr] <= vci_inc;
    end
    vci_rd <= vci_mem[vci_raddr];
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_kind     = out_kind;
  assign rsp.out_tag         = out_tag;
  assign rsp.out_vci         = out_vci;
  assign rsp.counter_value   = out_cval;
  assign rsp.queue_length    = QLEN_W'(fill);
  assign rsp.total_losses    = loss_sum;
  assign rsp.counter_wrapped = out_wrap;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= QUEUE_DEPTH)
    else $error("queue fill above depth");

  a_slot_fill_le_fill: assert property (@(posedge clk) disable iff (rst)
    slot_fill <= fill)
    else $error("slot start fill exceeds current fill");

  a_send_pops: assert property (@(posedge clk) disable iff (rst)
    (exec && command_t'(c_cmd) == CMD_TICK && sends) |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("sent cell did not leave the queue");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result raised outside the update cycle");

endmodule
`default_nettype wire

// ----- verif/cmfl_mux_checker.sv -----
`timescale 1ns / 1ps
module cmfl_mux_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cmfl_pkg::LIMIT_W-1:0]  cfg_data,
  cmfl_in_if                            req,
  cmfl_out_if                           rsp,
  output int                            fail_count,
  output int                            outstanding,
  output int                            drop_count,
  output int                            send_count
);
  import cmfl_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [VCI_W-1:0]   vci;
    logic [CNT_W-1:0]   count;
    logic [QLEN_W-1:0]  qlen;
    logic [CNT_W-1:0]   total;
    logic               wrapped;
  } mux_result_t;

  // shadow of the multiplexer
  logic [TAG_W-1:0]   cell_tags[$];
  logic [VCI_W-1:0]   cell_vcis[$];
  logic [QLEN_W-1:0]  slot_fill;
  logic [LIMIT_W-1:0] limit_reg;
  logic [CNT_W-1:0]   line_loss [NUM_INPUTS];
  logic [CNT_W-1:0]   vci_loss [MAX_VCI];
  logic [CNT_W-1:0]   loss_total;
  mux_result_t        expected_results[$];

  function automatic int field_diff(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic model_command(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] line,
                               input logic [VCI_W-1:0] vci, input logic has_vci,
                               input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] idx);
    mux_result_t r;
    int cap;
    r = '0;
    cap = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
    case (cmd)
      CMD_ARRIVE: begin
        if (cell_tags.size() < cap) begin
          cell_tags.push_back(tag);
          cell_vcis.push_back(has_vci ? vci : '0);
          r.kind = KIND_QUEUED;
        end else begin
          r.kind = KIND_DROPPED;
          drop_count++;
          if (line < NUM_INPUTS) begin
            line_loss[line] = line_loss[line] + CNT_W'(1);
            if (line_loss[line] == '0) r.wrapped = 1'b1;
          end
          // per-VCI counting only for cells that carry a small VCI
          if (has_vci && vci < MAX_VCI) begin
            vci_loss[vci[VCI_AW-1:0]] = vci_loss[vci[VCI_AW-1:0]] + CNT_W'(1);
            if (vci_loss[vci[VCI_AW-1:0]] == '0) r.wrapped = 1'b1;
          end
          loss_total = loss_total + CNT_W'(1);
          if (loss_total == '0) r.wrapped = 1'b1;
        end
      end
      CMD_TICK: begin
        // only cells present at the start of the slot may leave
        if (slot_fill != '0 && cell_tags.size() != 0) begin
          r.tag = cell_tags.pop_front();
          r.vci = cell_vcis.pop_front();
          r.kind = KIND_SENT;
          send_count++;
        end else begin
          r.kind = KIND_IDLE;
        end
        slot_fill = QLEN_W'(cell_tags.size());
      end
      CMD_CLEAR: begin
        foreach (line_loss[i]) line_loss[i] = '0;
        foreach (vci_loss[i]) vci_loss[i] = '0;
        loss_total = '0;
        r.kind = KIND_CLEARED;
      end
      CMD_READ_LINE: begin
        r.count = (idx < NUM_INPUTS) ? line_loss[idx] : '0;
        r.kind = KIND_READ;
      end
      CMD_READ_VCI: begin
        r.count = (idx < MAX_VCI) ? vci_loss[idx] : '0;
        r.kind = KIND_READ;
      end
      default: return;
    endcase
    r.qlen = QLEN_W'(cell_tags.size());
    r.total = loss_total;
    expected_results.push_back(r);
    outstanding++;
  endtask

  always @(posedge clk) begin
    mux_result_t want;
    if (rst) begin
      cell_tags.delete();
      cell_vcis.delete();
      expected_results.delete();
      foreach (line_loss[i]) line_loss[i] = '0;
      foreach (vci_loss[i]) vci_loss[i] = '0;
      loss_total = '0;
      slot_fill = '0;
      limit_reg = LIMIT_RESET;
      fail_count = 0;
      outstanding = 0;
      drop_count = 0;
      send_count = 0;
    end else begin
      if (cfg_we) limit_reg = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", rsp.result_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          outstanding--;
          fail_count += field_diff("result_kind", CNT_W'(want.kind),
                                   CNT_W'(rsp.result_kind));
          fail_count += field_diff("out_tag", want.tag, rsp.out_tag);
          fail_count += field_diff("out_vci", CNT_W'(want.vci), CNT_W'(rsp.out_vci));
          fail_count += field_diff("counter_value", want.count, rsp.counter_value);
          fail_count += field_diff("queue_length", CNT_W'(want.qlen),
                                   CNT_W'(rsp.queue_length));
          fail_count += field_diff("total_losses", want.total, rsp.total_losses);
          fail_count += field_diff("counter_wrapped", CNT_W'(want.wrapped),
                                   CNT_W'(rsp.counter_wrapped));
        end
      end
      if (req.valid && req.ready)
        model_command(req.command, req.input_line, req.cell_vci, req.has_vci,
                      req.cell_tag, req.counter_index);
    end
  end

endmodule

// ----- verif/cell_mux_fifo_loss_counter_core_tb.sv -----
`timescale 1ns / 1ps
module cell_mux_fifo_loss_counter_core_tb;
  import cmfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_BEATS    = 106;
  localparam logic [CMD_W-1:0] CMD_ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  logic sink_ready = 1'b0;

  int fail_count, outstanding, drop_count, send_count;
  int burst_left = 0;
  int beat_count = 0;
  int limits_used = 1;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  cmfl_in_if  req_if ();
  cmfl_out_if rsp_if ();

  cell_mux_fifo_loss_counter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  cmfl_mux_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req         (req_if),
    .rsp         (rsp_if),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .drop_count  (drop_count),
    .send_count  (send_count)
  );

  always #10 clk = ~clk;

  assign rsp_if.ready = sink_ready;

  // receiver: picks a new random stall behavior whenever its stall counter runs out
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 60);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: sink_ready <= 1'b1;
        1: sink_ready <= 1'($urandom_range(0, 1));
        2: sink_ready <= ($urandom_range(0, 3) == 0);
        default: sink_ready <= ~sink_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, outstanding);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] line,
                           input logic [VCI_W-1:0] vci, input logic has_vci,
                           input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.input_line    <= line;
    req_if.cell_vci      <= vci;
    req_if.has_vci       <= has_vci;
    req_if.cell_tag      <= tag;
    req_if.counter_index <= idx;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
    beat_count++;
  endtask

  // let every result come back, then let silent commands finish too
  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limits_used++;
  endtask

  task automatic random_beats(input int n, input int arrive_pct);
    logic [CMD_W-1:0] cmd;
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        cmd = CMD_W'($urandom_range(CMD_READ_VCI + 1, CMD_ALL_ONES));
      else if (roll < 5)
        cmd = CMD_CLEAR;
      else if (roll < 9)
        cmd = CMD_READ_LINE;
      else if (roll < 13)
        cmd = CMD_READ_VCI;
      else
        cmd = ($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_TICK;
      // bias VCIs into the counted range most of the time
      send_beat(cmd, LINE_W'($urandom),
                ($urandom_range(0, 9) < 7) ? VCI_W'($urandom_range(0, MAX_VCI - 1)) :
                                             VCI_W'($urandom),
                1'($urandom), $urandom, IDX_W'($urandom));
    end
  endtask

  initial begin
    int fixed_limits [5];
    logic [LIMIT_W-1:0] lim;
    fixed_limits         = '{1, 0, 64, 127, 5};
    req_if.valid         = 1'b0;
    req_if.command       = CMD_ARRIVE;
    req_if.input_line    = '0;
    req_if.cell_vci      = '0;
    req_if.has_vci       = 1'b0;
    req_if.cell_tag      = '0;
    req_if.counter_index = '0;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset limit of 10
    send_beat(CMD_READ_LINE, 0, 0, 0, 0, 0);
    send_beat(CMD_READ_VCI, 0, 0, 0, 0, IDX_W'(MAX_VCI - 1));
    send_beat(CMD_TICK, 0, 0, 0, 0, 0);              // empty queue, idle slot
    send_beat(CMD_W'(CMD_READ_VCI + 1), 0, 0, 0, 0, 0);  // unknown, no result
    for (int k = 0; k < 10; k++)
      send_beat(CMD_ARRIVE, LINE_W'(k + 6), (k == 0) ? 16'hFFFF : 16'(k), k[0],
                (k == 0) ? 32'h0 : ((k == 1) ? 32'hFFFF_FFFF : $urandom), 0);
    send_beat(CMD_ARRIVE, LINE_W'(NUM_INPUTS - 1), VCI_W'(MAX_VCI - 1), 1,
              $urandom, 0);                          // full: drop
    send_beat(CMD_ARRIVE, 0, 3, 0, $urandom, 0);     // drop without VCI
    send_beat(CMD_ARRIVE, 7, 16'hFFFF, 1, $urandom, 0);  // drop, VCI out of range
    send_beat(CMD_READ_LINE, 0, 0, 0, 0, IDX_W'(NUM_INPUTS - 1));
    send_beat(CMD_READ_VCI, 0, 0, 0, 0, IDX_W'(MAX_VCI - 1));
    send_beat(CMD_READ_VCI, 0, 0, 0, 0, 3);
    send_beat(CMD_TICK, 0, 0, 0, 0, 0);              // slot began empty: idle
    send_beat(CMD_TICK, 0, 0, 0, 0, 0);              // now a cell leaves
    send_beat(CMD_ALL_ONES, 0, 0, 0, 0, 0);
    send_beat(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_beat(CMD_READ_LINE, 0, 0, 0, 0, IDX_W'(NUM_INPUTS - 1));

    for (int p = 0; p < 8; p++) begin
      lim = (p < 5) ? LIMIT_W'(fixed_limits[p]) : LIMIT_W'($urandom_range(1, QUEUE_DEPTH));
      write_limit(lim);
      random_beats(PHASE_BEATS, (lim >= 32) ? 85 : $urandom_range(35, 70));
    end
    drain();

    $display("%0d command beats over %0d buffer limits (0, 1, 64, 127 among them)",
             beat_count, limits_used);
    $display("%0d cells sent, %0d cells dropped", send_count, drop_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cmfl_pkg.sv
rtl/core/cmfl_if.sv
rtl/core/cell_mux_fifo_loss_counter_core.sv
verif/cmfl_mux_checker.sv
verif/cell_mux_fifo_loss_counter_core_tb.sv
